FILE: sv/sufe_pkg.sv
// ----------------------------------------------------------------------------
// Seeded union-find forest package
// Shared widths, codes, the entry layout of the forest store and the state
// machine type of the seeded union-find engine.
// ----------------------------------------------------------------------------
`default_nettype none

package sufe_pkg;

	localparam int NODES   = 4096;
	localparam int NODE_W  = 12;
	localparam int CNT_W   = 13;
	localparam int LABEL_W = 8;
	localparam int RANK_W  = 4;

	localparam logic [RANK_W-1:0] RANK_MAX = '1;
	localparam logic [CNT_W-1:0]  CNT_MAX  = '1;
	localparam logic [CNT_W-1:0]  NODE_LIM = CNT_W'(NODES);

	typedef enum logic [1:0] {
		OP_SEED  = 2'd0,
		OP_MERGE = 2'd1,
		OP_READ  = 2'd2,
		OP_NOP   = 2'd3
	} op_t;

	typedef struct packed {
		logic [NODE_W-1:0]  parent;
		logic [RANK_W-1:0]  rank;
		logic [LABEL_W-1:0] mark;
	} entry_t;

	typedef struct packed {
		logic              we;
		logic [NODE_W-1:0] waddr;
		entry_t            wdata;
		logic [NODE_W-1:0] raddr;
	} mem_req_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FIND_A,
		ST_FIND_B,
		ST_LINK_LO,
		ST_LINK_HI,
		ST_SEED,
		ST_RESP
	} state_t;

endpackage

`default_nettype wire

FILE: sv/sufe_store.sv
// ----------------------------------------------------------------------------
// Seeded union-find forest store
// One synchronous memory holding parent, rank and label of every node, with
// a registered read and a clearing sweep after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module sufe_store (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire sufe_pkg::mem_req_t req,
	output sufe_pkg::entry_t       rdata,
	output logic                   sweeping
);

	sufe_pkg::entry_t                 mem [sufe_pkg::NODES];
	sufe_pkg::entry_t                 rdata_q;
	logic [sufe_pkg::NODE_W-1:0]      clr_q;
	logic                             sweep_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q   <= '0;
			sweep_q <= 1'b1;
		end else if (sweep_q) begin
			clr_q <= clr_q + sufe_pkg::NODE_W'(1);
			if (clr_q == '1) begin
				sweep_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (sweep_q) begin
			mem[clr_q] <= '{parent: clr_q, rank: '0, mark: '0};
		end else if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		rdata_q <= mem[req.raddr];
	end

	assign rdata    = rdata_q;
	assign sweeping = sweep_q;

endmodule

`default_nettype wire

FILE: sv/seeded_union_find_forest.sv
// ----------------------------------------------------------------------------
// Seeded union-find forest
// Union-find engine for seeded maximum spanning forest segmentation: seeds
// label nodes, merges join trees by rank, reads return a root's label.
//
//   channel  handshake                 payload
//   command  start, busy               operation, node_a, node_b, seed_label
//   result   done (one-cycle strobe)   merged, forest_complete, root_label
//   config   node_count_we             node_count_wdata
//
// A command with no effect (node out of range, seed label zero, merge on a
// complete forest or operation three) goes straight to its result beat; a seed
// reads its node and writes the label, a read follows parents to the root, and a
// merge finds both roots and, when the trees are joined, writes the lower-rank root
// and then the higher-rank one. A node is at most 12 parent steps from its root.
// The parent chase is bound by the single read port of the forest store.
// After reset busy stays high for a sweep that clears all 4096 store entries.
// Results cannot be held off; each is given for one cycle with done high.
// ----------------------------------------------------------------------------
`default_nettype none

module seeded_union_find_forest (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           start,
	output logic                                busy,
	input  wire logic [1:0]                     operation,
	input  wire logic [sufe_pkg::NODE_W-1:0]    node_a,
	input  wire logic [sufe_pkg::NODE_W-1:0]    node_b,
	input  wire logic [sufe_pkg::LABEL_W-1:0]   seed_label,
	output logic                                done,
	output logic                                merged,
	output logic                                forest_complete,
	output logic [sufe_pkg::LABEL_W-1:0]        root_label,
	input  wire logic                           node_count_we,
	input  wire logic [sufe_pkg::CNT_W-1:0]     node_count_wdata
);

	sufe_pkg::state_t                  state_q, state_d;
	sufe_pkg::mem_req_t                req;
	sufe_pkg::entry_t                  rdata;
	logic                              sweeping;

	logic [sufe_pkg::CNT_W-1:0]        node_count_q;
	logic [sufe_pkg::CNT_W-1:0]        merge_total_q;
	logic [sufe_pkg::CNT_W-1:0]        seed_total_q;
	logic                              done_q;
	logic                              merged_q;

	sufe_pkg::op_t                     op_q;
	logic [sufe_pkg::NODE_W-1:0]       cur_q;
	logic [sufe_pkg::NODE_W-1:0]       b_q;
	logic [sufe_pkg::LABEL_W-1:0]      lab_q;
	logic [sufe_pkg::LABEL_W-1:0]      label_q;
	logic [sufe_pkg::NODE_W-1:0]       x_q, y_q;
	sufe_pkg::entry_t                  x_ent_q, y_ent_q;
	logic                              merged_out_q;
	logic                              complete_out_q;
	logic [sufe_pkg::LABEL_W-1:0]      label_out_q;

	logic [sufe_pkg::CNT_W-1:0]        lim;
	logic [sufe_pkg::CNT_W:0]          total;
	logic                              complete;
	logic                              accept;
	logic                              a_ok, b_ok;
	logic                              at_root;
	logic                              swap;
	logic                              do_link;
	logic [sufe_pkg::NODE_W-1:0]       lo_idx, hi_idx;
	sufe_pkg::entry_t                  lo_ent, hi_ent;
	logic [sufe_pkg::RANK_W-1:0]       hi_rank_new;
	logic [sufe_pkg::LABEL_W-1:0]      new_mark;

	sufe_store u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.rdata    (rdata),
		.sweeping (sweeping)
	);

	assign busy   = sweeping || (state_q != sufe_pkg::ST_IDLE);
	assign accept = start && !busy;

	assign lim      = (node_count_q > sufe_pkg::NODE_LIM) ? sufe_pkg::NODE_LIM : node_count_q;
	assign total    = {1'b0, merge_total_q} + {1'b0, seed_total_q};
	assign complete = (total == {1'b0, lim});
	assign a_ok     = ({1'b0, node_a} < lim);
	assign b_ok     = ({1'b0, node_b} < lim);
	assign at_root  = (rdata.parent == cur_q);

	assign swap        = (x_ent_q.rank > y_ent_q.rank);
	assign lo_idx      = swap ? y_q : x_q;
	assign hi_idx      = swap ? x_q : y_q;
	assign lo_ent      = swap ? y_ent_q : x_ent_q;
	assign hi_ent      = swap ? x_ent_q : y_ent_q;
	assign hi_rank_new = ((lo_ent.rank == hi_ent.rank) && (hi_ent.rank != sufe_pkg::RANK_MAX))
		? hi_ent.rank + sufe_pkg::RANK_W'(1) : hi_ent.rank;
	assign new_mark    = (x_ent_q.mark != '0) ? x_ent_q.mark : y_ent_q.mark;
	assign do_link     = (x_q != y_q) && !((x_ent_q.mark != '0) && (y_ent_q.mark != '0));

	always_comb begin
		state_d = state_q;
		req     = '0;
		case (state_q)
			sufe_pkg::ST_IDLE: begin
				req.raddr = node_a;
				if (accept) begin
					case (sufe_pkg::op_t'(operation))
						sufe_pkg::OP_SEED: begin
							state_d = (a_ok && (seed_label != '0))
								? sufe_pkg::ST_SEED : sufe_pkg::ST_RESP;
						end
						sufe_pkg::OP_MERGE: begin
							state_d = (a_ok && b_ok && !complete)
								? sufe_pkg::ST_FIND_A : sufe_pkg::ST_RESP;
						end
						sufe_pkg::OP_READ: begin
							state_d = a_ok ? sufe_pkg::ST_FIND_A : sufe_pkg::ST_RESP;
						end
						default: begin
							state_d = sufe_pkg::ST_RESP;
						end
					endcase
				end
			end
			sufe_pkg::ST_FIND_A: begin
				if (at_root) begin
					if (op_q == sufe_pkg::OP_MERGE) begin
						req.raddr = b_q;
						state_d   = sufe_pkg::ST_FIND_B;
					end else begin
						state_d = sufe_pkg::ST_RESP;
					end
				end else begin
					req.raddr = rdata.parent;
				end
			end
			sufe_pkg::ST_FIND_B: begin
				if (at_root) begin
					state_d = sufe_pkg::ST_LINK_LO;
				end else begin
					req.raddr = rdata.parent;
				end
			end
			sufe_pkg::ST_LINK_LO: begin
				if (do_link) begin
					req.we    = 1'b1;
					req.waddr = lo_idx;
					req.wdata = '{parent: hi_idx, rank: lo_ent.rank, mark: lo_ent.mark};
					state_d   = sufe_pkg::ST_LINK_HI;
				end else begin
					state_d = sufe_pkg::ST_RESP;
				end
			end
			sufe_pkg::ST_LINK_HI: begin
				req.we    = 1'b1;
				req.waddr = hi_idx;
				req.wdata = '{parent: hi_idx, rank: hi_rank_new, mark: new_mark};
				state_d   = sufe_pkg::ST_RESP;
			end
			sufe_pkg::ST_SEED: begin
				req.we    = 1'b1;
				req.waddr = cur_q;
				req.wdata = '{parent: rdata.parent, rank: rdata.rank, mark: lab_q};
				state_d   = sufe_pkg::ST_RESP;
			end
			sufe_pkg::ST_RESP: begin
				state_d = sufe_pkg::ST_IDLE;
			end
			default: begin
				state_d = sufe_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= sufe_pkg::ST_IDLE;
			node_count_q  <= sufe_pkg::NODE_LIM;
			merge_total_q <= '0;
			seed_total_q  <= '0;
			done_q        <= 1'b0;
			merged_q      <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == sufe_pkg::ST_RESP);
			if (node_count_we) begin
				node_count_q <= node_count_wdata;
			end
			if (accept) begin
				merged_q <= 1'b0;
			end
			if (state_q == sufe_pkg::ST_LINK_HI) begin
				merged_q <= 1'b1;
				if (merge_total_q != sufe_pkg::CNT_MAX) begin
					merge_total_q <= merge_total_q + sufe_pkg::CNT_W'(1);
				end
			end
			if ((state_q == sufe_pkg::ST_SEED) && (rdata.mark == '0)
				&& (seed_total_q != sufe_pkg::CNT_MAX)) begin
				seed_total_q <= seed_total_q + sufe_pkg::CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q    <= sufe_pkg::op_t'(operation);
			cur_q   <= node_a;
			b_q     <= node_b;
			lab_q   <= seed_label;
			label_q <= '0;
		end
		if (state_q == sufe_pkg::ST_FIND_A) begin
			if (at_root) begin
				x_q     <= cur_q;
				x_ent_q <= rdata;
				cur_q   <= b_q;
				if (op_q == sufe_pkg::OP_READ) begin
					label_q <= rdata.mark;
				end
			end else begin
				cur_q <= rdata.parent;
			end
		end
		if (state_q == sufe_pkg::ST_FIND_B) begin
			if (at_root) begin
				y_q     <= cur_q;
				y_ent_q <= rdata;
			end else begin
				cur_q <= rdata.parent;
			end
		end
		if (state_q == sufe_pkg::ST_RESP) begin
			merged_out_q   <= merged_q;
			complete_out_q <= complete;
			label_out_q    <= label_q;
		end
	end

	assign done            = done_q;
	assign merged          = merged_out_q;
	assign forest_complete = complete_out_q;
	assign root_label      = label_out_q;

endmodule

`default_nettype wire
